/* src/btc_pkg.sv */
// ----------------------------------------------------------------------------
// btc_pkg
// Shared types and constants for the barometer trim compensation pipeline.
// ----------------------------------------------------------------------------
package btc_pkg;

  // Field widths of the payload and of the configuration port.
  localparam int unsigned RawW    = 24;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgW    = 48;

  // Signed width of the small multiplier operand (t or the raw pressure).
  localparam int unsigned XW = 25;

  // Width of the offset raw temperature.
  localparam int unsigned DW = 26;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    RegTempTrim   = 4'd0,
    RegPressTrimA = 4'd1,
    RegPressTrimB = 4'd2,
    RegPressTrimC = 4'd3
  } cfg_reg_e;

  // Input transaction.
  typedef struct packed {
    logic [RawW-1:0] raw_temperature;
    logic [RawW-1:0] raw_pressure;
  } in_t;

  // Result transaction.
  typedef struct packed {
    logic signed [23:0] temperature;
    logic [23:0]        pressure;
    logic               saturated;
  } out_t;

endpackage

/* src/barometer_trim_compensation_top.sv */
// ----------------------------------------------------------------------------
// barometer_trim_compensation_top
// Fixed-point trim compensation of raw barometer temperature and pressure.
// ----------------------------------------------------------------------------
// The block takes one raw reading pair per clock cycle when not stalled and
// returns the compensated temperature (2^-16 degC) and pressure (1/64 Pa)
// from an eleven-stage pipeline in which every multiplier is followed by a
// register and the pressure cubic in temperature is evaluated in Horner form
// through three two-stage multiply-accumulate units. Bubbles are squeezed out
// under output stalls; a full pipeline keeps one transaction per cycle while
// the output is ready. The user must write the trim registers through the
// configuration port only while no transaction is in flight (not enforced).
module barometer_trim_compensation_top import btc_pkg::*; #(
  parameter int unsigned RAW_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  localparam int unsigned NStg = 11;
  localparam logic [RawW-1:0] RawMask = RawW'((25'(1) << RAW_BITS) - 25'(1));

  // Trim registers.
  logic [39:0] temp_trim_q;
  logic [47:0] press_trim_a_q, press_trim_b_q;
  logic [31:0] press_trim_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_trim_q    <= '0;
      press_trim_a_q <= '0;
      press_trim_b_q <= '0;
      press_trim_c_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegTempTrim:   temp_trim_q    <= cfg_data_i[39:0];
        RegPressTrimA: press_trim_a_q <= cfg_data_i;
        RegPressTrimB: press_trim_b_q <= cfg_data_i;
        RegPressTrimC: press_trim_c_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // Trim field decode.
  logic [15:0]        tr_t1, tr_t2, tr_p5, tr_p6;
  logic signed [7:0]  tr_t3, tr_p3, tr_p4, tr_p7, tr_p8, tr_p10, tr_p11;
  logic signed [15:0] tr_p9;
  logic signed [16:0] tr_p1m, tr_p2m;

  always_comb begin
    tr_t1  = temp_trim_q[15:0];
    tr_t2  = temp_trim_q[31:16];
    tr_t3  = signed'(temp_trim_q[39:32]);
    tr_p1m = 17'(signed'(press_trim_a_q[15:0])) - 17'sd16384;
    tr_p2m = 17'(signed'(press_trim_a_q[31:16])) - 17'sd16384;
    tr_p3  = signed'(press_trim_a_q[39:32]);
    tr_p4  = signed'(press_trim_a_q[47:40]);
    tr_p5  = press_trim_b_q[15:0];
    tr_p6  = press_trim_b_q[31:16];
    tr_p7  = signed'(press_trim_b_q[39:32]);
    tr_p8  = signed'(press_trim_b_q[47:40]);
    tr_p9  = signed'(press_trim_c_q[15:0]);
    tr_p10 = signed'(press_trim_c_q[23:16]);
    tr_p11 = signed'(press_trim_c_q[31:24]);
  end

  // Stage enables: a stage loads when it is empty or its successor moves.
  logic [NStg:1] v_q;
  logic [NStg:1] en;

  always_comb begin
    en[NStg] = !v_q[NStg] || out_ready_i;
    for (int k = NStg - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= NStg; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = en[1];
  assign out_valid_o = v_q[NStg];

  // Stage 1: mask raw readings and offset the temperature.
  logic [RawW-1:0]      rt_m, u_m;
  logic signed [DW-1:0] d_d, d1_q;
  logic [RawW-1:0]      u1_q;

  always_comb begin
    rt_m = in_data_i.raw_temperature & RawMask;
    u_m  = in_data_i.raw_pressure & RawMask;
    d_d  = signed'({2'b00, rt_m}) - signed'({2'b00, tr_t1, 8'h00});
  end

  // Stage 2: raw-pressure terms of the coefficients.
  logic signed [XW-1:0] u1s;
  logic signed [33:0]   c2_d, a2_d, a3_d, c2_q, a2_q, a3_q;
  logic signed [37:0]   e_d, e_q;
  logic [RawW-1:0]      u2_q, u3_q, u4_q;

  always_comb begin
    u1s  = signed'({1'b0, u1_q});
    c2_d = (34'(tr_p9) <<< 17) + 34'(u1s) * 34'(tr_p11);
    e_d  = (38'(tr_p2m) <<< 19) + 38'(u1s) * 38'(tr_p10);
    a2_d = (34'(tr_p7) <<< 24) + 34'(u1s) * 34'(tr_p3);
    a3_d = (34'(tr_p8) <<< 22) + 34'(u1s) * 34'(tr_p4);
  end

  // Temperature polynomial, stages 2 to 4.
  logic signed [23:0] t4;
  logic               st4;

  btc_temp u_temp (
    .clk_i (clk_i),
    .en_i  (en[4:2]),
    .d_i   (d1_q),
    .t2_i  (tr_t2),
    .t3_i  (tr_t3),
    .t_o   (t4),
    .sat_o (st4)
  );

  // Stages 3 and 4: c1 = (P1-2^14)*2^45 + u*c2 and a1 = P6*2^42 + u*e.
  logic signed [XW-1:0] u2s, u4s;
  logic signed [62:0]   c1_add;
  logic signed [63:0]   c1;
  logic signed [58:0]   a1_add;
  logic signed [62:0]   a1, a1_5_q, a1_6_q;

  assign u2s    = signed'({1'b0, u2_q});
  assign u4s    = signed'({1'b0, u4_q});
  assign c1_add = 63'(tr_p1m) <<< 45;
  assign a1_add = signed'({1'b0, tr_p6, 42'd0});

  btc_mulacc #(.YW(34), .AW(63), .OW(64)) u_mul_uc2 (
    .clk_i (clk_i),
    .en_i  (en[4:3]),
    .x_i   (u2s),
    .y_i   (c2_q),
    .add_i (c1_add),
    .sum_o (c1)
  );

  btc_mulacc #(.YW(38), .AW(59), .OW(63)) u_mul_ue (
    .clk_i (clk_i),
    .en_i  (en[4:3]),
    .x_i   (u2s),
    .y_i   (e_q),
    .add_i (a1_add),
    .sum_o (a1)
  );

  // Delay lines for coefficients, temperature and the clip flag.
  logic signed [33:0] a2_3_q, a3_3_q, a2_4_q, a3_4_q;
  logic signed [23:0] t5_q, t6_q, t7_q, t8_q, t9_q, t10_q;
  logic               st5_q, st6_q, st7_q, st8_q, st9_q, st10_q;
  logic signed [89:0] a0, a0_7_q, a0_8_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      d1_q <= d_d;
      u1_q <= u_m;
    end
    if (en[2]) begin
      u2_q <= u1_q;
      c2_q <= c2_d;
      e_q  <= e_d;
      a2_q <= a2_d;
      a3_q <= a3_d;
    end
    if (en[3]) begin
      u3_q   <= u2_q;
      a2_3_q <= a2_q;
      a3_3_q <= a3_q;
    end
    if (en[4]) begin
      u4_q   <= u3_q;
      a2_4_q <= a2_3_q;
      a3_4_q <= a3_3_q;
    end
    if (en[5]) begin
      t5_q   <= t4;
      st5_q  <= st4;
      a1_5_q <= a1;
    end
    if (en[6]) begin
      t6_q   <= t5_q;
      st6_q  <= st5_q;
      a1_6_q <= a1_5_q;
    end
    if (en[7]) begin
      t7_q   <= t6_q;
      st7_q  <= st6_q;
      a0_7_q <= a0;
    end
    if (en[8]) begin
      t8_q   <= t7_q;
      st8_q  <= st7_q;
      a0_8_q <= a0_7_q;
    end
    if (en[9]) begin
      t9_q  <= t8_q;
      st9_q <= st8_q;
    end
    if (en[10]) begin
      t10_q  <= t9_q;
      st10_q <= st9_q;
    end
  end

  // Stages 5 and 6: B2 = a2*2^21 + t*a3, and A0 = P5*2^68 + u*c1.
  logic signed [XW-1:0] t4s, t6s, t8s;
  logic signed [54:0]   b2_add;
  logic signed [58:0]   b2;
  logic signed [84:0]   a0_add;

  assign t4s    = XW'(t4);
  assign t6s    = XW'(t6_q);
  assign t8s    = XW'(t8_q);
  assign b2_add = 55'(a2_4_q) <<< 21;
  assign a0_add = signed'({1'b0, tr_p5, 68'd0});

  btc_mulacc #(.YW(34), .AW(55), .OW(59)) u_mul_t3 (
    .clk_i (clk_i),
    .en_i  (en[6:5]),
    .x_i   (t4s),
    .y_i   (a3_4_q),
    .add_i (b2_add),
    .sum_o (b2)
  );

  btc_mulacc #(.YW(64), .AW(85), .OW(90)) u_mul_uc1 (
    .clk_i (clk_i),
    .en_i  (en[6:5]),
    .x_i   (u4s),
    .y_i   (c1),
    .add_i (a0_add),
    .sum_o (a0)
  );

  // Stages 7 and 8: B1 = a1*2^21 + t*B2.
  logic signed [83:0] b1_add;
  logic signed [85:0] b1;

  assign b1_add = 84'(a1_6_q) <<< 21;

  btc_mulacc #(.YW(59), .AW(84), .OW(86)) u_mul_t2 (
    .clk_i (clk_i),
    .en_i  (en[8:7]),
    .x_i   (t6s),
    .y_i   (b2),
    .add_i (b1_add),
    .sum_o (b1)
  );

  // Stages 9 and 10: pressure * 2^85 = A0*2^20 + t*B1.
  logic signed [109:0] acc_add;
  logic signed [111:0] acc;

  assign acc_add = 110'(a0_8_q) <<< 20;

  btc_mulacc #(.YW(86), .AW(110), .OW(112)) u_mul_t1 (
    .clk_i (clk_i),
    .en_i  (en[10:9]),
    .x_i   (t8s),
    .y_i   (b1),
    .add_i (acc_add),
    .sum_o (acc)
  );

  // Stage 11: scale to 1/64 Pa with round half up, clip, and register.
  logic signed [111:0] acc_r;
  logic [32:0]         p_full;
  out_t                out_d, out_q;

  always_comb begin
    acc_r  = acc + (112'sd1 <<< 78);
    p_full = acc_r[111:79];
    out_d.temperature = t10_q;
    out_d.saturated   = st10_q;
    if (acc_r[111]) begin
      out_d.pressure  = '0;
      out_d.saturated = 1'b1;
    end else if (p_full > 33'h0_00FF_FFFF) begin
      out_d.pressure  = 24'hFF_FFFF;
      out_d.saturated = 1'b1;
    end else begin
      out_d.pressure = p_full[23:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NStg]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

/* src/btc_mulacc.sv */
// ----------------------------------------------------------------------------
// btc_mulacc
// Two-stage multiply-accumulate: sum = add + x * y. The wide operand y is cut
// into 32-bit chunks whose partial products are registered, then summed.
// ----------------------------------------------------------------------------
module btc_mulacc import btc_pkg::*; #(
  parameter int unsigned YW = 34,
  parameter int unsigned AW = 60,
  parameter int unsigned OW = 64
) (
  input  logic                 clk_i,
  input  logic [1:0]           en_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [YW-1:0] y_i,
  input  logic signed [AW-1:0] add_i,
  output logic signed [OW-1:0] sum_o
);

  localparam int unsigned NCh  = (YW + 31) / 32;
  localparam int unsigned YExt = NCh * 32;
  localparam int unsigned PpW  = XW + 33;

  logic signed [YExt-1:0] y_ext;
  logic signed [32:0]     chunk   [NCh];
  logic signed [PpW-1:0]  pp_d    [NCh];
  logic signed [PpW-1:0]  pp_q    [NCh];
  logic signed [AW-1:0]   add_q;
  logic signed [OW-1:0]   sum_d;
  logic signed [OW-1:0]   sum_q;

  // Partial products: low chunks are unsigned, the top chunk carries the sign.
  always_comb begin
    y_ext = YExt'(y_i);
    for (int i = 0; i < NCh; i++) begin
      if (i == NCh - 1) begin
        chunk[i] = {y_ext[32*i+31], y_ext[32*i +: 32]};
      end else begin
        chunk[i] = {1'b0, y_ext[32*i +: 32]};
      end
      pp_d[i] = PpW'(x_i) * PpW'(chunk[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pp_q  <= pp_d;
      add_q <= add_i;
    end
  end

  // Align the partial products and add them to the addend.
  always_comb begin
    sum_d = OW'(add_q);
    for (int i = 0; i < NCh; i++) begin
      sum_d = sum_d + (OW'(pp_q[i]) <<< (32 * i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

/* src/btc_temp.sv */
// ----------------------------------------------------------------------------
// btc_temp
// Three-stage temperature polynomial: d*T2*2^18 + d*d*T3, rounded to units of
// 2^-16 degC and clipped to the signed 24-bit range.
// ----------------------------------------------------------------------------
module btc_temp import btc_pkg::*; (
  input  logic                 clk_i,
  input  logic [2:0]           en_i,
  input  logic signed [DW-1:0] d_i,
  input  logic [15:0]          t2_i,
  input  logic signed [7:0]    t3_i,
  output logic signed [23:0]   t_o,
  output logic                 sat_o
);

  logic signed [42:0] m1_d, m1_q, m1d_q;
  logic signed [51:0] dd_d, dd_q;
  logic signed [58:0] p3_d, p3_q;
  logic signed [61:0] tx;
  logic signed [29:0] t_full;
  logic signed [23:0] t_d, t_q;
  logic               sat_d, sat_q;

  // Stage one: linear and square terms.
  always_comb begin
    m1_d = 43'(d_i) * 43'(signed'({1'b0, t2_i}));
    dd_d = 52'(d_i) * 52'(d_i);
  end

  // Stage two: scale the square by T3.
  assign p3_d = 59'(dd_q) * 59'(t3_i);

  // Stage three: sum, round half up, and clip.
  always_comb begin
    tx     = (62'(m1d_q) <<< 18) + 62'(p3_q) + 62'sd2147483648;
    t_full = 30'(tx >>> 32);
    sat_d  = 1'b0;
    if (t_full > 30'sd8388607) begin
      t_d   = 24'sd8388607;
      sat_d = 1'b1;
    end else if (t_full < -30'sd8388608) begin
      t_d   = -24'sd8388608;
      sat_d = 1'b1;
    end else begin
      t_d = 24'(t_full);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      m1_q <= m1_d;
      dd_q <= dd_d;
    end
    if (en_i[1]) begin
      m1d_q <= m1_q;
      p3_q  <= p3_d;
    end
    if (en_i[2]) begin
      t_q   <= t_d;
      sat_q <= sat_d;
    end
  end

  assign t_o   = t_q;
  assign sat_o = sat_q;

endmodule

/* verif/barometer_trim_compensation_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// barometer_trim_compensation_checker
// Watches the input, result and trim-write channels of the compensation block,
// computes the expected compensated readings and compares every result.
// ----------------------------------------------------------------------------
module barometer_trim_compensation_checker import btc_pkg::*; #(
  parameter int unsigned RAW_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  in_t                in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  out_t               out_data_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 results_o
);

  typedef logic signed [127:0] wide_t;

  // Local copy of the trim words.
  logic [39:0] temp_trim;
  logic [47:0] press_trim_a;
  logic [47:0] press_trim_b;
  logic [31:0] press_trim_c;

  out_t readings_q[$];

  // Exact fixed-point compensation of one raw reading pair.
  function automatic out_t compensate(in_t x);
    longint t1, t2, t3, d, tx, tc, rt, ru;
    wide_t wt, wu, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11, acc, pw;
    logic   sat;
    out_t   r;
    rt  = longint'(x.raw_temperature & ((1 << RAW_BITS) - 1));
    ru  = longint'(x.raw_pressure & ((1 << RAW_BITS) - 1));
    sat = 1'b0;
    t1  = temp_trim[15:0];
    t2  = temp_trim[31:16];
    t3  = $signed(temp_trim[39:32]);
    // Temperature scaled by 2^48, rounded half up to 2^-16 degC.
    d  = rt - t1 * 256;
    tx = d * t2 * 262144 + d * d * t3;
    tc = (tx + (64'sd1 <<< 31)) >>> 32;
    if (tc > 8388607) begin
      tc  = 8388607;
      sat = 1'b1;
    end
    if (tc < -8388608) begin
      tc  = -8388608;
      sat = 1'b1;
    end
    // Pressure scaled by 2^85 in a wide accumulator.
    wt  = tc;
    wu  = ru;
    p1  = longint'($signed(press_trim_a[15:0])) - 16384;
    p2  = longint'($signed(press_trim_a[31:16])) - 16384;
    p3  = $signed(press_trim_a[39:32]);
    p4  = $signed(press_trim_a[47:40]);
    p5  = longint'(press_trim_b[15:0]);
    p6  = longint'(press_trim_b[31:16]);
    p7  = $signed(press_trim_b[39:32]);
    p8  = $signed(press_trim_b[47:40]);
    p9  = $signed(press_trim_c[15:0]);
    p10 = $signed(press_trim_c[23:16]);
    p11 = $signed(press_trim_c[31:24]);
    acc = (p5 <<< 88) + ((p6 * wt) <<< 63) + ((p7 * wt * wt) <<< 45)
        + ((p8 * wt * wt * wt) <<< 22) + ((wu * p1) <<< 65)
        + ((wu * p2 * wt) <<< 40) + ((wu * p3 * wt * wt) <<< 21)
        + (wu * p4 * wt * wt * wt) + ((wu * wu * p9) <<< 37)
        + ((wu * wu * p10 * wt) <<< 21) + ((wu * wu * wu * p11) <<< 20);
    acc = acc + (wide_t'(1) <<< 78);
    r.temperature = tc[23:0];
    if (acc[127]) begin
      r.pressure = '0;
      sat        = 1'b1;
    end else begin
      pw = acc >>> 79;
      if (pw > 128'sh0FF_FFFF) begin
        r.pressure = 24'hFF_FFFF;
        sat        = 1'b1;
      end else begin
        r.pressure = pw[23:0];
      end
    end
    r.saturated = sat;
    return r;
  endfunction

  // Channel monitor: trim writes, predictions and result comparison.
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      temp_trim    = '0;
      press_trim_a = '0;
      press_trim_b = '0;
      press_trim_c = '0;
      readings_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      results_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegTempTrim:   temp_trim    = cfg_data_i[39:0];
          RegPressTrimA: press_trim_a = cfg_data_i[47:0];
          RegPressTrimB: press_trim_b = cfg_data_i[47:0];
          RegPressTrimC: press_trim_c = cfg_data_i[31:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        readings_q.push_back(compensate(in_data_i));
      end
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (readings_q.size() == 0) begin
          $error("result transaction with no expectation waiting");
          fail_count_o++;
        end else begin
          want = readings_q.pop_front();
          if (out_data_i.temperature !== want.temperature) begin
            $error("temperature: expected %0d, actual %0d",
                   want.temperature, out_data_i.temperature);
            fail_count_o++;
          end
          if (out_data_i.pressure !== want.pressure) begin
            $error("pressure: expected %0d, actual %0d",
                   want.pressure, out_data_i.pressure);
            fail_count_o++;
          end
          if (out_data_i.saturated !== want.saturated) begin
            $error("saturated: expected %0d, actual %0d",
                   want.saturated, out_data_i.saturated);
            fail_count_o++;
          end
        end
      end
      pending_o = readings_q.size();
    end
  end

endmodule

/* verif/barometer_trim_compensation_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// barometer_trim_compensation_top_tb
// Drives raw reading pairs and trim settings into the compensation pipeline
// under varying back-pressure; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module barometer_trim_compensation_top_tb;
  import btc_pkg::*;

  localparam int Phases     = 9;
  localparam int PhaseItems = 160;
  localparam int DrainWait  = 30;
  localparam int HoldCycles = 300;
  localparam int CycleLimit = 400000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  in_t                in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  out_t               out_data_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0]    cfg_data_i;

  int fail_count;
  int pending;
  int results;
  int items_sent;
  int cycles;
  int snd_idle;
  int rcv_idle;
  bit hold_req;
  int cur_t1;
  bit typical_trim;

  barometer_trim_compensation_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  barometer_trim_compensation_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results)
  );

  // Clock.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Run-length guard.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result receiver with random stalls and one long hold-off on request.
  initial begin
    bit held;
    held        = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // One input transaction, followed by random idle cycles.
  task automatic send_item(in_t d);
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    if ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle);
    end
  endtask

  // Wait until every expected result has come and the pipeline is empty.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // One trim-register write transaction.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_trims(logic [39:0] tt, logic [47:0] pa, logic [47:0] pb,
                               logic [31:0] pc);
    write_reg(RegTempTrim, CfgW'(tt));
    write_reg(RegPressTrimA, pa);
    write_reg(RegPressTrimB, pb);
    write_reg(RegPressTrimC, CfgW'(pc));
    cur_t1 = tt[15:0];
  endtask

  // Trim set close to a real factory calibration.
  task automatic program_typical();
    logic [15:0] t1, t2, p1, p2, p5, p6, p9;
    logic [7:0]  t3, p3, p4, p7, p8, p10, p11;
    t1  = 16'(26000 + $urandom_range(3000));
    t2  = 16'(17000 + $urandom_range(4000));
    t3  = 8'(-int'($urandom_range(12)));
    p1  = 16'(int'($urandom_range(4000)) - 2000);
    p2  = 16'(-int'($urandom_range(3000)));
    p3  = 8'(20 + $urandom_range(20));
    p4  = 8'(int'($urandom_range(4)) - 2);
    p5  = 16'(24000 + $urandom_range(3000));
    p6  = 16'(28000 + $urandom_range(4000));
    p7  = 8'(int'($urandom_range(8)) - 4);
    p8  = 8'(-int'($urandom_range(8)));
    p9  = 16'(15000 + $urandom_range(2000));
    p10 = 8'(int'($urandom_range(8)) - 4);
    p11 = 8'(-int'($urandom_range(80)));
    program_trims({t3, t2, t1}, {p4, p3, p2, p1}, {p8, p7, p6, p5}, {p11, p10, p9});
  endtask

  function automatic in_t rand_reading();
    in_t r;
    int  off;
    if (typical_trim && $urandom_range(9) < 7) begin
      off = int'($urandom_range(1200000)) - 600000;
      r.raw_temperature = RawW'(cur_t1 * 256 + off);
      r.raw_pressure    = RawW'(5000000 + $urandom_range(5000000));
    end else begin
      r.raw_temperature = RawW'($urandom());
      r.raw_pressure    = RawW'($urandom());
    end
    return r;
  endfunction

  // Stimulus and verdict.
  initial begin
    in_t it;
    int  kind;
    items_sent   = 0;
    snd_idle     = 0;
    rcv_idle     = 0;
    hold_req     = 1'b0;
    typical_trim = 1'b0;
    cur_t1       = 0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset trims: field extremes of the raw readings.
    send_item('{raw_temperature: '0, raw_pressure: '0});
    send_item('{raw_temperature: '1, raw_pressure: '1});
    send_item('{raw_temperature: 24'h80_0000, raw_pressure: 24'h7F_FFFF});
    drain();

    // Temperature rounding ties: half-step values round up; the largest reading clips high.
    program_trims(40'h00_2000_0000, 48'h0000_0000_4000, 48'h0, 32'h0);
    send_item('{raw_temperature: 24'd1, raw_pressure: 24'd0});
    send_item('{raw_temperature: 24'd3, raw_pressure: 24'd0});
    send_item('{raw_temperature: 24'hFF_FFFF, raw_pressure: 24'd0});
    drain();
    // Negative offset reading drives temperature below range.
    program_trims(40'h7F_FFFF_FFFF, 48'h0000_0000_4000, 48'h0, 32'h0);
    send_item('{raw_temperature: 24'd0, raw_pressure: 24'd5});
    send_item('{raw_temperature: 24'hFF_FFFF, raw_pressure: 24'd5});
    drain();
    // Pressure rounding tie, and negative pressure clipped to zero.
    program_trims(40'h0, 48'h0000_4000_4001, 48'h0, 32'h0);
    send_item('{raw_temperature: 24'd0, raw_pressure: 24'd8192});
    send_item('{raw_temperature: 24'd0, raw_pressure: 24'd24576});
    drain();
    program_trims(40'h0, 48'h0000_4000_0000, 48'h0, 32'h0);
    send_item('{raw_temperature: 24'd0, raw_pressure: 24'd100});
    drain();
    // Pressure beyond the top of range, and all-ones trims.
    program_trims(40'h0, 48'h0000_4000_4000, 48'h0000_0000_FFFF, 32'h0);
    send_item('{raw_temperature: 24'd0, raw_pressure: 24'd0});
    drain();
    program_trims('1, '1, '1, '1);
    send_item('{raw_temperature: 24'h12_3456, raw_pressure: 24'hAB_CDEF});
    send_item('{raw_temperature: '1, raw_pressure: '1});
    drain();
    // Writes to unknown indexes must leave the trims alone.
    write_reg(CfgIdxW'(4 + $urandom_range(11)), '1);
    write_reg(CfgIdxW'(4 + $urandom_range(11)), '0);
    send_item('{raw_temperature: 24'h00_0100, raw_pressure: 24'h00_0100});
    drain();

    // Random phases with a new trim set each.
    for (int ph = 0; ph < Phases; ph++) begin
      snd_idle = (ph < 3) ? 34 : (ph < 6) ? 72 : 0;
      rcv_idle = (ph < 3) ? 72 : (ph < 6) ? 34 : 0;
      kind = (ph == 0) ? 0 : (ph == 4) ? 1 : (ph == 7) ? 4 : (ph % 2 == 1) ? 2 : 3;
      typical_trim = (kind == 3);
      case (kind)
        0: program_trims('0, '0, '0, '0);
        1: program_trims('1, '1, '1, '1);
        2: program_trims(40'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
                         48'({$urandom(), $urandom()}), $urandom());
        3: program_typical();
        default: program_trims(40'h80_8000_8000, 48'h80_80_8000_8000,
                               48'h80_80_0000_0000, 32'h80_80_8000);
      endcase
      if ($urandom_range(1) == 1) write_reg(CfgIdxW'(4 + $urandom_range(11)), '1);
      if (ph == 6) hold_req = 1'b1;
      for (int n = 0; n < PhaseItems; n++) begin
        it = rand_reading();
        send_item(it);
        // Let the pipeline empty completely once in mid-phase.
        if (ph == 3 && n == 80) drain();
      end
      drain();
    end

    $display("Covered %0d reading pairs and %0d results over %0d trim settings,",
             items_sent, results, Phases + 7);
    $display("with rounding ties, clipping at both ends and long output stalls.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/btc_pkg.sv
src/btc_mulacc.sv
src/btc_temp.sv
src/barometer_trim_compensation_top.sv
verif/barometer_trim_compensation_checker.sv
verif/barometer_trim_compensation_top_tb.sv
